/* design/bps_pkg.sv */
package bps_pkg;

    localparam int DEFAULT_FLOWS = 16;
    localparam int DATA_W = 32;
    localparam int INDEX_W = 4;
    localparam int PROD_W = 64;
    localparam int RBL_W = 38;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_INIT,
        ST_RD,
        ST_MUL,
        ST_DIV,
        ST_DEC,
        ST_PASS,
        ST_ORD,
        ST_OUT
    } state_t;

endpackage

/* design/bps_ram.sv */
module bps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* design/bps_div.sv */
module bps_div
    import bps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [PROD_W-1:0] dividend,
    input  logic [RBL_W-1:0]  divisor,
    output logic              busy,
    output logic [PROD_W-1:0] quotient
);

    logic [PROD_W-1:0] quo_reg, quo_next;
    logic [RBL_W:0]    rem_reg, rem_next;
    logic [6:0]        cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic [RBL_W:0]    trial;

    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {rem_reg[RBL_W-1:0], quo_reg[PROD_W-1]};
        if (start)
        begin
            quo_next = dividend;
            rem_next = '0;
            cnt_next = 7'(PROD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, divisor})
            begin
                rem_next = trial - {1'b0, divisor};
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign busy = busy_reg;
    assign quotient = quo_reg;

endmodule

/* design/backlog_proportional_share.sv */
// Collects one beat per flow into on-chip RAM; the beat with last_flow set starts the
// allocation, which first sums the backlogs of the set of n flows. Each visit to an
// uncapped flow runs a 64-step radix-2 divider, and a capped flow is skipped. A set
// needs up to n+1 passes before the n share beats are delivered, one at a time while
// the output is not stalled. Input beats and configuration writes are stalled from the
// last flow until the final share beat is taken.
module backlog_proportional_share
    import bps_pkg::*;
#(
    parameter int FLOWS = DEFAULT_FLOWS,
    localparam int AW = (FLOWS > 1) ? $clog2(FLOWS) : 1,
    localparam int CW = $clog2(FLOWS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [DATA_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [DATA_W-1:0]   flow_backlog,
    input  logic [DATA_W-1:0]   flow_request,
    input  logic                last_flow,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [DATA_W-1:0]   flow_share,
    output logic [INDEX_W-1:0]  flow_index,
    output logic                last_share
);

    state_t state_reg, state_next;
    logic [DATA_W-1:0] cap_reg;
    logic [DATA_W-1:0] rcap_reg, rcap_next;
    logic [RBL_W-1:0]  rbl_reg, rbl_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [FLOWS-1:0]  capped_reg, capped_next;
    logic              pass_reg, pass_next;
    logic [PROD_W-1:0] prod;
    logic [DATA_W-1:0] bl_q, rq_q, sh_q;
    logic              sh_we;
    logic [DATA_W-1:0] sh_wd;
    logic [AW-1:0]     raddr, ld_addr;
    logic              ld_we;
    logic              ov_reg, ov_next;
    logic              olast_reg, olast_next;
    logic [INDEX_W-1:0] oidx_reg, oidx_next;
    logic              div_start;
    logic              div_busy;
    logic [PROD_W-1:0] quo;
    logic [PROD_W-1:0] share64;

    assign ld_addr = cnt_reg[AW-1:0];
    assign ld_we = (state_reg == ST_LOAD) && in_valid && (cnt_reg < CW'(FLOWS));

    bps_ram #(.WIDTH(DATA_W), .DEPTH(FLOWS)) u_bl (
        .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(flow_backlog),
        .raddr(raddr), .rdata(bl_q));
    bps_ram #(.WIDTH(DATA_W), .DEPTH(FLOWS)) u_rq (
        .clk(clk), .we(ld_we), .waddr(ld_addr), .wdata(flow_request),
        .raddr(raddr), .rdata(rq_q));
    bps_ram #(.WIDTH(DATA_W), .DEPTH(FLOWS)) u_sh (
        .clk(clk), .we(sh_we), .waddr(idx_reg[AW-1:0]), .wdata(sh_wd),
        .raddr(raddr), .rdata(sh_q));

    assign prod = PROD_W'(rcap_reg) * PROD_W'(bl_q);

    bps_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(prod), .divisor(rbl_reg),
        .busy(div_busy), .quotient(quo));

    assign cfg_ready = (state_reg == ST_LOAD);
    assign in_stall = (state_reg != ST_LOAD);
    assign share64 = (bl_q == '0 || rbl_reg == '0) ? '0 : quo;

    always_comb
    begin
        state_next = state_reg;
        rcap_next = rcap_reg;
        rbl_next = rbl_reg;
        cnt_next = cnt_reg;
        idx_next = idx_reg;
        capped_next = capped_reg;
        pass_next = pass_reg;
        ov_next = ov_reg;
        olast_next = olast_reg;
        oidx_next = oidx_reg;
        raddr = idx_reg[AW-1:0];
        sh_we = 1'b0;
        sh_wd = share64[DATA_W-1:0];
        div_start = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_valid)
                begin
                    if (cnt_reg < CW'(FLOWS))
                    begin
                        cnt_next = cnt_reg + CW'(1);
                    end
                    if (last_flow)
                    begin
                        if (cnt_reg < CW'(FLOWS))
                        begin
                            cnt_next = cnt_reg + CW'(1);
                        end
                        idx_next = '0;
                        rbl_next = '0;
                        rcap_next = cap_reg;
                        capped_next = '0;
                        state_next = ST_INIT;
                    end
                end
            end
            ST_INIT:
            begin
                if (idx_reg != '0)
                begin
                    rbl_next = rbl_reg + RBL_W'(bl_q);
                end
                if (idx_reg == cnt_reg)
                begin
                    idx_next = '0;
                    pass_next = 1'b0;
                    state_next = ST_RD;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                    raddr = idx_reg[AW-1:0];
                end
            end
            ST_RD:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = ST_PASS;
                end
                else if (capped_reg[idx_reg[AW-1:0]])
                begin
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                div_start = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = ST_DEC;
                end
            end
            ST_DEC:
            begin
                sh_we = 1'b1;
                if (PROD_W'(rq_q) < share64)
                begin
                    sh_wd = rq_q;
                    rbl_next = rbl_reg - RBL_W'(bl_q);
                    rcap_next = rcap_reg - rq_q;
                    capped_next[idx_reg[AW-1:0]] = 1'b1;
                    pass_next = 1'b1;
                end
                idx_next = idx_reg + CW'(1);
                state_next = ST_RD;
            end
            ST_PASS:
            begin
                idx_next = '0;
                if (pass_reg)
                begin
                    pass_next = 1'b0;
                    state_next = ST_RD;
                end
                else
                begin
                    state_next = ST_ORD;
                end
            end
            ST_ORD:
            begin
                raddr = idx_reg[AW-1:0];
                oidx_next = INDEX_W'(idx_reg);
                olast_next = (idx_reg + CW'(1) == cnt_reg);
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                ov_next = 1'b1;
                if (ov_reg && !out_stall)
                begin
                    ov_next = 1'b0;
                    if (olast_reg)
                    begin
                        cnt_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                        state_next = ST_ORD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_LOAD;
            cap_reg <= '0;
            rcap_reg <= '0;
            rbl_reg <= '0;
            cnt_reg <= '0;
            idx_reg <= '0;
            capped_reg <= '0;
            pass_reg <= 1'b0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rcap_reg <= rcap_next;
            rbl_reg <= rbl_next;
            cnt_reg <= cnt_next;
            idx_reg <= idx_next;
            capped_reg <= capped_next;
            pass_reg <= pass_next;
            ov_reg <= ov_next;
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        olast_reg <= olast_next;
        oidx_reg <= oidx_next;
    end

    assign out_valid = ov_reg;
    assign flow_share = sh_q;
    assign flow_index = oidx_reg;
    assign last_share = olast_reg;

endmodule
